// File: src/rgb_to_hsv_cylinder_position_assert.svh
// Assertion helpers for the top-level RTL file.
`ifndef RGB_TO_HSV_CYLINDER_POSITION_ASSERT_SVH
`define RGB_TO_HSV_CYLINDER_POSITION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define RHC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/rhc_pkg.sv
package rhc_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int FRAC_BITS    = 14;
    localparam int TRIG_STAGES  = 16;
    localparam int GUARD_BITS   = 8;
    localparam int HUE_BITS     = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;

    // atan(2^-i) in units of 2^32 per turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

// File: src/rhc_div_cell.sv
module rhc_div_cell #(
    parameter int DW = 11,
    parameter int QD = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QD-1:0] i_dvd,
    input  logic [QD-1:0] i_quo,
    input  logic [DW-1:0] i_div,
    output logic [DW-1:0] o_rem,
    output logic [QD-1:0] o_dvd,
    output logic [QD-1:0] o_quo,
    output logic [DW-1:0] o_div
);
    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {i_rem, i_dvd[QD-1]};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? DW'(w_trial - {1'b0, i_div}) : DW'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_dvd <= {i_dvd[QD-2:0], 1'b0};
            o_quo <= {i_quo[QD-2:0], w_ge};
            o_div <= i_div;
        end
    end
endmodule

// File: src/rhc_cordic_cell.sv
module rhc_cordic_cell #(
    parameter int XW  = 25,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [31:0]   i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [31:0]   o_z
);
    import rhc_pkg::*;

    localparam logic signed [31:0] C_ANG = signed'(ATAN_TURN32[IDX]);

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;

    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;

    // rotate toward zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_z >= 0) begin
                o_x <= i_x - w_ys;
                o_y <= i_y + w_xs;
                o_z <= i_z - C_ANG;
            end else begin
                o_x <= i_x + w_ys;
                o_y <= i_y - w_xs;
                o_z <= i_z + C_ANG;
            end
        end
    end
endmodule

// File: src/rgb_to_hsv_cylinder_position.sv
// RGB pixel to HSV, placed on a cylinder (x = cos(hue)*sat, z = sin(hue)*sat,
// y = 0.5 - value).
// Input channel: i_valid / o_ready with i_red, i_green, i_blue. A transaction
// is taken at a clock edge where both are high.
// Output channel: o_valid / i_ready with the position, hue, saturation and value.
// Throughput: one pixel per clock while i_ready does not stall the output. The pipeline is an
// input register, the restoring divider rows (one quotient bit per cell), a scaling register,
// the CORDIC row (one rotation per cell) and an output register.
// All stages advance together; when the receiver holds i_ready low with a result
// waiting, the whole row holds and o_ready drops until the result is taken.
// Pipeline stages without a transaction simply carry a bubble.
// Reset (synchronous, active low) drops every in-flight transaction; the block
// keeps no other state.
`include "rgb_to_hsv_cylinder_position_assert.svh"
module rgb_to_hsv_cylinder_position #(
    parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS,
    parameter int FRAC_BITS    = rhc_pkg::FRAC_BITS,
    parameter int TRIG_STAGES  = rhc_pkg::TRIG_STAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pos_x,
    output logic [14:0] o_pos_y,
    output logic [15:0] o_pos_z,
    output logic [15:0] o_hue_turn,
    output logic [14:0] o_saturation_frac,
    output logic [7:0]  o_value_level
);
    import rhc_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int F  = FRAC_BITS;
    localparam int QD = (HUE_BITS + 1 > F + 1) ? HUE_BITS + 1 : F + 1;
    localparam int NS = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
    localparam int HW = CB + 3;
    localparam int SW = CB + 1;
    localparam int XW = F + GUARD_BITS + 3;
    localparam int PW = F + 1 + GUARD_BITS + 30 + 1;
    localparam int L  = QD + NS + 3;
    localparam logic [SW-1:0] C_CMASK = SW'((1 << CB) - 1);
    localparam logic [SW-1:0] C_VDIV  = SW'(2 * ((1 << CB) - 1));
    // value level by reciprocal multiplication: exact while numerator * error < 2^VS
    localparam int VW = CB + F + 2;
    localparam int MW = VW + 1;
    localparam int VS = VW + SW;
    localparam longint unsigned C_VRECIP_L =
        ((64'd1 << VS) + 64'(C_VDIV) - 64'd1) / 64'(C_VDIV);
    localparam logic [MW-1:0] C_VRECIP = MW'(C_VRECIP_L);

    logic         w_en;
    logic [L-1:0] r_vld;

    assign w_en    = !r_vld[L-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // input register
    logic [CB-1:0] r_r, r_g, r_b;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r <= CB'(i_red);
            r_g <= CB'(i_green);
            r_b <= CB'(i_blue);
        end
    end

    // max/min, sector numerator, divider operands
    logic [CB-1:0]    w_mx, w_mn, w_d;
    logic [HW-1:0]    w_np, w_dd, w_rr, w_gg, w_bb;
    logic [HW+QD-1:0] w_hdvd;
    logic [SW+QD-1:0] w_sdvd;

    always_comb begin
        w_mx = r_r;
        if (r_g > w_mx) w_mx = r_g;
        if (r_b > w_mx) w_mx = r_b;
        w_mn = r_r;
        if (r_g < w_mn) w_mn = r_g;
        if (r_b < w_mn) w_mn = r_b;
        w_d  = w_mx - w_mn;
        w_dd = HW'(w_d);
        w_rr = HW'(r_r);
        w_gg = HW'(r_g);
        w_bb = HW'(r_b);
        // numerator already reduced into one turn of 6*delta
        priority if (r_r == w_mx) begin
            w_np = (r_g >= r_b) ? (w_gg - w_bb) : (HW'(6 * w_dd) + w_gg - w_bb);
        end else if (r_g == w_mx) begin
            w_np = HW'(2 * w_dd) + w_bb - w_rr;
        end else begin
            w_np = HW'(4 * w_dd) + w_rr - w_gg;
        end
        w_hdvd = ((HW+QD)'(w_np) << HUE_BITS) + (HW+QD)'(HW'(3 * w_dd));
        w_sdvd = ((SW+QD)'(w_d) << (F + 1)) + (SW+QD)'(w_mx);
    end

    // divider rows: hue, saturation
    logic [HW-1:0] w_hrem [QD+1];
    logic [HW-1:0] w_hdiv [QD+1];
    logic [QD-1:0] w_hlow [QD+1];
    logic [QD-1:0] w_hquo [QD+1];
    logic [SW-1:0] w_srem [QD+1];
    logic [SW-1:0] w_sdiv [QD+1];
    logic [QD-1:0] w_slow [QD+1];
    logic [QD-1:0] w_squo [QD+1];

    assign w_hrem[0] = w_hdvd[HW+QD-1:QD];
    assign w_hlow[0] = w_hdvd[QD-1:0];
    assign w_hquo[0] = '0;
    assign w_hdiv[0] = HW'(6 * w_dd);
    assign w_srem[0] = w_sdvd[SW+QD-1:QD];
    assign w_slow[0] = w_sdvd[QD-1:0];
    assign w_squo[0] = '0;
    assign w_sdiv[0] = {w_mx, 1'b0};

    for (genvar k = 0; k < QD; k++) begin : g_div
        rhc_div_cell #(.DW(HW), .QD(QD)) u_hue (
            .i_clk(i_clk), .i_en(w_en),
            .i_rem(w_hrem[k]), .i_dvd(w_hlow[k]), .i_quo(w_hquo[k]), .i_div(w_hdiv[k]),
            .o_rem(w_hrem[k+1]), .o_dvd(w_hlow[k+1]), .o_quo(w_hquo[k+1]),
            .o_div(w_hdiv[k+1])
        );
        rhc_div_cell #(.DW(SW), .QD(QD)) u_sat (
            .i_clk(i_clk), .i_en(w_en),
            .i_rem(w_srem[k]), .i_dvd(w_slow[k]), .i_quo(w_squo[k]), .i_div(w_sdiv[k]),
            .o_rem(w_srem[k+1]), .o_dvd(w_slow[k+1]), .o_quo(w_squo[k+1]),
            .o_div(w_sdiv[k+1])
        );
    end

    logic [CB-1:0] r_d_mx   [QD];
    logic          r_d_grey [QD];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_mx[0]   <= w_mx;
            r_d_grey[0] <= (w_d == '0);
            for (int k = 1; k < QD; k++) begin
                r_d_mx[k]   <= r_d_mx[k-1];
                r_d_grey[k] <= r_d_grey[k-1];
            end
        end
    end

    // gain scaling, value level and quadrant split
    logic [HUE_BITS-1:0]  w_hue;
    logic [F:0]           w_sat;
    logic [PW-1:0]        w_prod;
    logic [VW-1:0]        w_vnum;
    logic [VW+MW-1:0]     w_vprod;
    logic [F:0]           w_vq;
    logic [HUE_BITS-1:0]  r_m_hue;
    logic [F:0]           r_m_sat;
    logic [CB-1:0]        r_m_mx;
    logic                 r_m_grey;
    logic signed [F+1:0]  r_m_posy;
    logic [1:0]           r_m_quad;
    logic signed [31:0]   r_m_z;
    logic signed [XW-1:0] r_m_x;

    assign w_hue   = w_hquo[QD][HUE_BITS-1:0];
    assign w_sat   = w_squo[QD][F:0];
    assign w_prod  = PW'({w_sat, {GUARD_BITS{1'b0}}}) * PW'(INV_GAIN_Q30);
    assign w_vnum  = (VW'(r_d_mx[QD-1]) << (F + 1)) + VW'(C_CMASK);
    assign w_vprod = (VW+MW)'(w_vnum) * (VW+MW)'(C_VRECIP);
    assign w_vq    = w_vprod[VS +: F + 1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_hue  <= w_hue;
            r_m_sat  <= w_sat;
            r_m_mx   <= r_d_mx[QD-1];
            r_m_grey <= r_d_grey[QD-1];
            r_m_posy <= (F+2)'(1 << (F - 1)) - (F+2)'(w_vq);
            r_m_quad <= w_hue[15:14] + {1'b0, w_hue[13]};
            r_m_z    <= signed'({{2{w_hue[13]}}, w_hue[13:0], 16'b0});
            r_m_x    <= signed'(XW'((w_prod + (PW'(1) << 29)) >> 30));
        end
    end

    // CORDIC row
    logic signed [XW-1:0] w_cx [NS+1];
    logic signed [XW-1:0] w_cy [NS+1];
    logic signed [31:0]   w_cz [NS+1];

    assign w_cx[0] = r_m_x;
    assign w_cy[0] = '0;
    assign w_cz[0] = r_m_z;

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        rhc_cordic_cell #(.XW(XW), .IDX(k)) u_cell (
            .i_clk(i_clk), .i_en(w_en),
            .i_x(w_cx[k]), .i_y(w_cy[k]), .i_z(w_cz[k]),
            .o_x(w_cx[k+1]), .o_y(w_cy[k+1]), .o_z(w_cz[k+1])
        );
    end

    logic [HUE_BITS-1:0] r_c_hue  [NS];
    logic [F:0]          r_c_sat  [NS];
    logic [CB-1:0]       r_c_mx   [NS];
    logic                r_c_grey [NS];
    logic signed [F+1:0] r_c_posy [NS];
    logic [1:0]          r_c_quad [NS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_hue[0]  <= r_m_hue;
            r_c_sat[0]  <= r_m_sat;
            r_c_mx[0]   <= r_m_mx;
            r_c_grey[0] <= r_m_grey;
            r_c_posy[0] <= r_m_posy;
            r_c_quad[0] <= r_m_quad;
            for (int k = 1; k < NS; k++) begin
                r_c_hue[k]  <= r_c_hue[k-1];
                r_c_sat[k]  <= r_c_sat[k-1];
                r_c_mx[k]   <= r_c_mx[k-1];
                r_c_grey[k] <= r_c_grey[k-1];
                r_c_posy[k] <= r_c_posy[k-1];
                r_c_quad[k] <= r_c_quad[k-1];
            end
        end
    end

    // quadrant rotation, rounding and limiting
    localparam logic signed [XW+1:0] C_LIM  = (XW+2)'(1 << F);
    localparam logic signed [XW+1:0] C_HALF = (XW+2)'(1 << (GUARD_BITS - 1));

    logic signed [XW+1:0] w_rx, w_ry, w_px, w_pz;

    always_comb begin
        unique case (r_c_quad[NS-1])
            2'd1: begin
                w_rx = -(XW+2)'(w_cy[NS]);
                w_ry =  (XW+2)'(w_cx[NS]);
            end
            2'd2: begin
                w_rx = -(XW+2)'(w_cx[NS]);
                w_ry = -(XW+2)'(w_cy[NS]);
            end
            2'd3: begin
                w_rx =  (XW+2)'(w_cy[NS]);
                w_ry = -(XW+2)'(w_cx[NS]);
            end
            default: begin
                w_rx = (XW+2)'(w_cx[NS]);
                w_ry = (XW+2)'(w_cy[NS]);
            end
        endcase
        w_px = (w_rx + C_HALF) >>> GUARD_BITS;
        w_pz = (w_ry + C_HALF) >>> GUARD_BITS;
        if (w_px > C_LIM)  w_px = C_LIM;
        if (w_px < -C_LIM) w_px = -C_LIM;
        if (w_pz > C_LIM)  w_pz = C_LIM;
        if (w_pz < -C_LIM) w_pz = -C_LIM;
        if (r_c_grey[NS-1]) begin
            w_px = '0;
            w_pz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_pos_x           <= 16'(w_px);
            o_pos_z           <= 16'(w_pz);
            o_pos_y           <= 15'(r_c_posy[NS-1]);
            o_hue_turn        <= r_c_grey[NS-1] ? '0 : r_c_hue[NS-1];
            o_saturation_frac <= r_c_grey[NS-1] ? '0 : 15'(r_c_sat[NS-1]);
            o_value_level     <= 8'(r_c_mx[NS-1]);
        end
    end

    `RHC_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_vld[0])
    `RHC_ASSERT_NXT(a_stall_holds, !o_ready, $stable(r_vld))
    `RHC_ASSERT_IMP(a_black_is_grey, o_valid && o_pos_y == 15'(1 << (F - 1)), o_saturation_frac == '0 && o_hue_turn == '0)
    `RHC_ASSERT_IMP(a_sat_bound, o_valid, o_saturation_frac <= 15'(1 << F))
endmodule

// File: tb/sv/tb_top.sv
module tb_top;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_pos_x;
    logic [14:0] o_pos_y;
    logic [15:0] o_pos_z;
    logic [15:0] o_hue_turn;
    logic [14:0] o_saturation_frac;
    logic [7:0]  o_value_level;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [14:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] hue_turn;
        logic [14:0] saturation_frac;
        logic [7:0]  value_level;
    } t_hsv_pos;

    localparam int CB = rhc_pkg::CHANNEL_BITS;
    localparam int FB = rhc_pkg::FRAC_BITS;
    localparam int GB = rhc_pkg::GUARD_BITS;
    localparam int LATENCY = 36;

    t_pixel   pixel_queue[$];
    t_hsv_pos expected_queue[$];
    int       error_count;
    int       pixels_sent;
    int       results_seen;
    int       grey_seen;
    bit       stim_done;

    rgb_to_hsv_cylinder_position dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(longint v, int n);
        if (v >= 0) return v >>> n;
        return -((-(v + 1)) >>> n) - 1;
    endfunction

    function automatic longint round_limit(longint v);
        longint r;
        longint lim;
        r = floor_shift(v + (64'sd1 << (GB - 1)), GB);
        lim = 64'sd1 << FB;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_hsv_pos convert_pixel(t_pixel p);
        longint cmask, r, g, b, mx, mn, d, num, vq, posy, hue, sat, px, pz;
        longint a32, q, rr, z, x, y, t, xs, ys;
        t_hsv_pos res;
        cmask = (64'sd1 << CB) - 1;
        r = p.red & cmask;
        g = p.green & cmask;
        b = p.blue & cmask;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hue = 0; sat = 0; px = 0; pz = 0;
        vq = (mx * (64'sd2 << FB) + cmask) / (2 * cmask);
        posy = (64'sd1 << (FB - 1)) - vq;
        if (d > 0) begin
            if (r >= mx) num = g - b;
            else if (g >= mx) num = 2 * d + b - r;
            else num = 4 * d + r - g;
            hue = ((num + 6 * d) * 65536 + 3 * d) / (6 * d);
            hue = hue & 64'hFFFF;
            sat = (d * (64'sd2 << FB) + mx) / (2 * mx);
            a32 = hue << 16;
            q = a32 >> 30;
            rr = a32 & 64'h3FFF_FFFF;
            if (rr >= 64'h2000_0000) begin
                q++;
                z = rr - 64'h4000_0000;
            end else begin
                z = rr;
            end
            q = q & 3;
            x = ((sat << GB) * longint'(rhc_pkg::INV_GAIN_Q30) + (64'sd1 << 29)) >>> 30;
            y = 0;
            for (int i = 0; i < rhc_pkg::TRIG_STAGES && i < rhc_pkg::ATAN_ENTRIES; i++) begin
                xs = floor_shift(x, i);
                ys = floor_shift(y, i);
                if (z >= 0) begin
                    x -= ys; y += xs; z -= longint'(rhc_pkg::ATAN_TURN32[i]);
                end else begin
                    x += ys; y -= xs; z += longint'(rhc_pkg::ATAN_TURN32[i]);
                end
            end
            if (q == 1) begin
                t = x; x = -y; y = t;
            end else if (q == 2) begin
                x = -x; y = -y;
            end else if (q == 3) begin
                t = x; x = y; y = -t;
            end
            px = round_limit(x);
            pz = round_limit(y);
        end
        res.pos_x = px[15:0];
        res.pos_y = posy[14:0];
        res.pos_z = pz[15:0];
        res.hue_turn = hue[15:0];
        res.saturation_frac = sat[14:0];
        res.value_level = mx[7:0];
        return res;
    endfunction

    function automatic t_pixel make_pixel(int r, int g, int b);
        t_pixel p;
        p.red = r[7:0];
        p.green = g[7:0];
        p.blue = b[7:0];
        return p;
    endfunction

    function automatic void queue_pixel(int r, int g, int b);
        pixel_queue = {pixel_queue, make_pixel(r, g, b)};
    endfunction

    initial begin
        int r, g, b, mode;
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        // negative hue wrap and near-full-turn rounding
        queue_pixel(255, 0, 1);
        queue_pixel(255, 0, 254);
        queue_pixel(1, 0, 0);
        queue_pixel(1, 1, 0);
        queue_pixel(0, 1, 1);
        queue_pixel(200, 200, 100);
        queue_pixel(100, 200, 200);
        queue_pixel(200, 100, 200);
        queue_pixel(255, 254, 253);
        queue_pixel(170, 85, 0);
        queue_pixel(1, 255, 128);
        for (int n = 0; n < 1650; n++) begin
            mode = $urandom_range(0, 9);
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            if (mode == 0) begin
                g = r; b = r;
            end else if (mode == 1) begin
                g = r;
            end else if (mode == 2) begin
                b = g;
            end else if (mode == 3) begin
                g = (r + $urandom_range(0, 2)) % 256;
                b = (r + $urandom_range(0, 2)) % 256;
            end
            queue_pixel(r, g, b);
        end
    end

    int burst_left;
    int gap_left;
    int stall_phase;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_red <= '0;
            i_green <= '0;
            i_blue <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (i_valid && !o_ready) begin
            // hold transaction until accepted
        end else begin
            if (i_valid) begin
                expected_queue = {expected_queue, convert_pixel({i_red, i_green, i_blue})};
                pixels_sent <= pixels_sent + 1;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pixel_queue.size() == 0) begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end else begin
                t_pixel p;
                p = pixel_queue.pop_front();
                i_valid <= 1'b1;
                i_red <= p.red;
                i_green <= p.green;
                i_blue <= p.blue;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            t_hsv_pos act, exp_res;
            stall_phase <= stall_phase + 1;
            if (o_valid && i_ready) begin
                act = {o_pos_x, o_pos_y, o_pos_z, o_hue_turn, o_saturation_frac,
                       o_value_level};
                results_seen <= results_seen + 1;
                if (expected_queue.size() == 0) begin
                    $error("result with no pending expectation");
                    error_count++;
                end else begin
                    exp_res = expected_queue.pop_front();
                    if (exp_res.saturation_frac == 0) grey_seen <= grey_seen + 1;
                    if (act.pos_x !== exp_res.pos_x) begin
                        $error("pos_x exp %h act %h", exp_res.pos_x, act.pos_x);
                        error_count++;
                    end
                    if (act.pos_y !== exp_res.pos_y) begin
                        $error("pos_y exp %h act %h", exp_res.pos_y, act.pos_y);
                        error_count++;
                    end
                    if (act.pos_z !== exp_res.pos_z) begin
                        $error("pos_z exp %h act %h", exp_res.pos_z, act.pos_z);
                        error_count++;
                    end
                    if (act.hue_turn !== exp_res.hue_turn) begin
                        $error("hue_turn exp %h act %h", exp_res.hue_turn, act.hue_turn);
                        error_count++;
                    end
                    if (act.saturation_frac !== exp_res.saturation_frac) begin
                        $error("saturation_frac exp %h act %h", exp_res.saturation_frac,
                               act.saturation_frac);
                        error_count++;
                    end
                    if (act.value_level !== exp_res.value_level) begin
                        $error("value_level exp %h act %h", exp_res.value_level,
                               act.value_level);
                        error_count++;
                    end
                end
            end
            // stall in windows: free-running stretch, a periodic stall pattern, then random stalls
            if ((stall_phase % 512) < 128) i_ready <= 1'b1;
            else if ((stall_phase % 512) < 160) i_ready <= ((stall_phase % 7) < 2);
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        error_count = 0;
        pixels_sent = 0;
        results_seen = 0;
        grey_seen = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && !i_valid && expected_queue.size() == 0);
        repeat (LATENCY * 2) @(posedge i_clk);
        if (expected_queue.size() != 0) begin
            $error("%0d expectations left over", expected_queue.size());
            error_count++;
        end
        $display("Converted %0d pixels, checked %0d results (%0d grey).",
                 pixels_sent, results_seen, grey_seen);
        if (error_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/rhc_pkg.sv
src/rhc_div_cell.sv
src/rhc_cordic_cell.sv
src/rgb_to_hsv_cylinder_position.sv
tb/sv/tb_top.sv
